// File: design/vad_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vad_pkg
// shared types and constants of the energy based voice activity endpointer
// ----------------------------------------------------------------------------
package vad_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_CHUNK   = 4096;
    localparam int CHUNK_CNT_W = $clog2(MAX_CHUNK + 1);
    localparam int MAG_W       = SAMPLE_BITS + 1;
    localparam int SQ_W        = 2 * SAMPLE_BITS - 1;
    localparam int ENERGY_W    = SQ_W + CHUNK_CNT_W - 1;

    localparam int THR_W = 30;
    localparam int CNT_W = 20;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [THR_W-1:0] THR_RESET     = THR_W'(107374);
    localparam logic [CNT_W-1:0] TIMEOUT_RESET = CNT_W'(32000);
    localparam logic [CNT_W-1:0] MAX_REC_RESET = CNT_W'(160000);

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_TIMEOUT   = 2'd1,
        REG_MAX_REC   = 2'd2,
        REG_NONE      = 2'd3
    } reg_index_t;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_START  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STOP_NONE    = 2'd0,
        STOP_SILENCE = 2'd1,
        STOP_MAX     = 2'd2,
        STOP_UNUSED  = 2'd3
    } stop_reason_t;

    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic [CNT_W-1:0] timeout;
        logic [CNT_W-1:0] max_rec;
    } cfg_t;

    typedef struct packed {
        cmd_t            cmd;
        logic            last;
        logic [SQ_W-1:0] square;
    } in_item_t;

    typedef struct packed {
        logic             chunk_done;
        logic             chunk_silent;
        logic             chunk_kept;
        logic             speech_started;
        logic             stop;
        stop_reason_t     stop_reason;
        logic             entirely_silent;
        logic [CNT_W-1:0] recorded_samples;
    } result_t;

endpackage
`default_nettype wire

// File: design/vad_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vad_cfg
// apb register file holding threshold, silence timeout and maximum length
// ----------------------------------------------------------------------------
module vad_cfg import vad_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t index;
    logic       wr_en;

    assign pready = 1'b1;
    assign index  = reg_index_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (index)
                REG_THRESHOLD: cfg_next.threshold = pwdata[THR_W-1:0];
                REG_TIMEOUT:   cfg_next.timeout   = pwdata[CNT_W-1:0];
                REG_MAX_REC:   cfg_next.max_rec   = pwdata[CNT_W-1:0];
                REG_NONE:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_THRESHOLD: prdata = DATA_W'(cfg_reg.threshold);
            REG_TIMEOUT:   prdata = DATA_W'(cfg_reg.timeout);
            REG_MAX_REC:   prdata = DATA_W'(cfg_reg.max_rec);
            REG_NONE:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold <= THR_RESET;
            cfg_reg.timeout   <= TIMEOUT_RESET;
            cfg_reg.max_rec   <= MAX_REC_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// File: design/vad_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vad_in_stage
// input register that squares the incoming sample
// ----------------------------------------------------------------------------
module vad_in_stage import vad_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_cmd,
    input  wire logic [SAMPLE_BITS-1:0] s_sample,
    input  wire logic                   s_last,
    output logic                        item_valid,
    input  wire logic                   item_ready,
    output in_item_t                    item
);

    logic               valid_reg;
    logic               valid_next;
    in_item_t           item_reg;
    logic               load;
    logic [MAG_W-1:0]   mag;
    logic [2*MAG_W-1:0] sq_full;

    // magnitude of the two's complement sample, most negative value included
    assign mag     = s_sample[SAMPLE_BITS-1] ? (MAG_W'(0) - {1'b1, s_sample})
                                             : {1'b0, s_sample};
    assign sq_full = mag * mag;

    assign s_ready = !valid_reg || item_ready;
    assign load    = s_valid && s_ready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (item_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.cmd    <= cmd_t'(s_cmd);
            item_reg.last   <= s_last;
            item_reg.square <= sq_full[SQ_W-1:0];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

// File: design/vad_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vad_core
// chunk energy accumulation, silence decision, session control, result register
// ----------------------------------------------------------------------------
module vad_core import vad_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  cfg_t      cfg,
    input  wire logic item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      out_valid,
    input  wire logic out_ready,
    output result_t   result
);

    logic [ENERGY_W-1:0]    energy_reg, energy_next;
    logic [CHUNK_CNT_W-1:0] chunk_cnt_reg, chunk_cnt_next;
    logic                   speech_reg, speech_next;
    logic                   all_silent_reg, all_silent_next;
    logic [CNT_W-1:0]       silent_run_reg, silent_run_next;
    logic [CNT_W-1:0]       kept_total_reg, kept_total_next;
    logic                   active_reg, active_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                result_reg, result_next;

    logic                   advance;
    logic [ENERGY_W-1:0]    energy_add;
    logic [ENERGY_W-1:0]    thr_limit;
    logic [CHUNK_CNT_W-1:0] cnt_inc;
    logic                   chunk_end;
    logic                   is_silent;
    logic [CNT_W:0]         run_sum;
    logic [CNT_W-1:0]       run_sat;
    logic [CNT_W:0]         kept_sum;
    logic [CNT_W-1:0]       kept_sat;
    logic                   kept;

    assign item_ready = !out_valid_reg || out_ready;
    assign advance    = item_valid && item_ready;

    // threshold times sample count, compared against the chunk energy
    assign energy_add = energy_reg + ENERGY_W'(item.square);
    assign cnt_inc    = chunk_cnt_reg + CHUNK_CNT_W'(1);
    assign thr_limit  = ENERGY_W'(cfg.threshold) * ENERGY_W'(cnt_inc);
    assign chunk_end  = item.last || (cnt_inc == CHUNK_CNT_W'(MAX_CHUNK));
    assign is_silent  = energy_add < thr_limit;

    assign run_sum  = {1'b0, silent_run_reg} + (CNT_W+1)'(cnt_inc);
    assign run_sat  = run_sum[CNT_W] ? CNT_MAX : run_sum[CNT_W-1:0];
    assign kept_sum = {1'b0, kept_total_reg} + (CNT_W+1)'(cnt_inc);
    assign kept_sat = kept_sum[CNT_W] ? CNT_MAX : kept_sum[CNT_W-1:0];

    always_comb
    begin
        energy_next     = energy_reg;
        chunk_cnt_next  = chunk_cnt_reg;
        speech_next     = speech_reg;
        all_silent_next = all_silent_reg;
        silent_run_next = silent_run_reg;
        kept_total_next = kept_total_reg;
        active_next     = active_reg;
        kept            = 1'b0;

        result_next                = result_reg;
        result_next.chunk_done     = 1'b0;
        result_next.chunk_silent   = 1'b0;
        result_next.chunk_kept     = 1'b0;
        result_next.stop           = 1'b0;
        result_next.stop_reason    = STOP_NONE;

        if (item.cmd == CMD_START)
        begin
            if (!active_reg)
            begin
                energy_next     = '0;
                chunk_cnt_next  = '0;
                speech_next     = 1'b0;
                all_silent_next = 1'b1;
                silent_run_next = '0;
                kept_total_next = '0;
                active_next     = 1'b1;
            end
        end
        else if (active_reg)
        begin
            if (!chunk_end)
            begin
                energy_next    = energy_add;
                chunk_cnt_next = cnt_inc;
            end
            else
            begin
                result_next.chunk_done   = 1'b1;
                result_next.chunk_silent = is_silent;
                kept                     = 1'b1;
                if (!speech_reg)
                begin
                    if (!is_silent)
                    begin
                        speech_next     = 1'b1;
                        all_silent_next = 1'b0;
                    end
                end
                else if (is_silent)
                begin
                    silent_run_next = run_sat;
                    if (run_sat >= cfg.timeout)
                    begin
                        kept                    = 1'b0;
                        result_next.stop        = 1'b1;
                        result_next.stop_reason = STOP_SILENCE;
                    end
                end
                else
                begin
                    silent_run_next = '0;
                    all_silent_next = 1'b0;
                end
                if (kept)
                begin
                    kept_total_next = kept_sat;
                    if (kept_sat >= cfg.max_rec)
                    begin
                        result_next.stop        = 1'b1;
                        result_next.stop_reason = STOP_MAX;
                    end
                end
                result_next.chunk_kept = kept;
                energy_next            = '0;
                chunk_cnt_next         = '0;
                if (result_next.stop)
                    active_next = 1'b0;
            end
        end

        result_next.speech_started   = speech_next;
        result_next.entirely_silent  = all_silent_next;
        result_next.recorded_samples = kept_total_next;
    end

    always_comb
    begin
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg     <= '0;
            chunk_cnt_reg  <= '0;
            speech_reg     <= 1'b0;
            all_silent_reg <= 1'b1;
            silent_run_reg <= '0;
            kept_total_reg <= '0;
            active_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                energy_reg     <= energy_next;
                chunk_cnt_reg  <= chunk_cnt_next;
                speech_reg     <= speech_next;
                all_silent_reg <= all_silent_next;
                silent_run_reg <= silent_run_next;
                kept_total_reg <= kept_total_next;
                active_reg     <= active_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    a_stop_ends_session: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.stop |-> !active_reg)
        else $error("session still active after a stop result");

    a_reason_with_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_reg.stop == (result_reg.stop_reason != STOP_NONE)))
        else $error("stop reason does not match stop flag");

    a_flags_need_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.chunk_done
            |-> !result_reg.chunk_silent && !result_reg.chunk_kept && !result_reg.stop)
        else $error("chunk flags set without a chunk end");

    a_chunk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        chunk_cnt_reg < CHUNK_CNT_W'(MAX_CHUNK))
        else $error("chunk count passed its limit");

    a_speech_clears_silent: assert property (@(posedge clk) disable iff (!rst_n)
        speech_reg |-> !all_silent_reg)
        else $error("speech seen but session marked all silent");

endmodule
`default_nettype wire

// File: design/energy_vad_endpointer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// energy_vad_endpointer
// energy based voice activity endpointer with apb configuration
// ----------------------------------------------------------------------------
// path: a request passes the input register and then the result register
// before it is offered; both hold while the result is not taken
// throughput: one request per cycle while m_tready does not hold the result
// reset: asynchronous, clears session state, loads register defaults
// ----------------------------------------------------------------------------
module energy_vad_endpointer import vad_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [15:0]       s_tdata,  // sample
    input  wire logic [0:0]        s_tuser,  // cmd
    input  wire logic              s_tlast,  // last_in_chunk
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // chunk_done, chunk_silent, chunk_kept, speech_started, stop,
    // stop_reason[1:0], entirely_silent, recorded_samples[19:0], zero pad
    output logic      [31:0]       m_tdata
);

    cfg_t     cfg;
    logic     item_valid;
    logic     item_ready;
    in_item_t item;
    result_t  result;

    vad_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vad_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_cmd      (s_tuser[0]),
        .s_sample   (s_tdata),
        .s_last     (s_tlast),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    vad_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .result     (result)
    );

    assign m_tdata = {4'b0000,
                      result.recorded_samples,
                      result.entirely_silent,
                      result.stop_reason,
                      result.stop,
                      result.speech_started,
                      result.chunk_kept,
                      result.chunk_silent,
                      result.chunk_done};

endmodule
`default_nettype wire
